FILE: rtl/core/mahd_pkg.sv
// mpeg audio header decode package: status codes, rate tables and
// reciprocal constants for the frame length computation
// depends on nothing
package mahd_pkg;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NO_SYNC     = 3'd1,
		ST_BAD_VERSION = 3'd2,
		ST_BAD_LAYER   = 3'd3,
		ST_BAD_RATE    = 3'd4
	} status_t;

	localparam logic [31:0] SYNC_MASK = 32'hFFE0_0000;

	// version field codes in the header
	localparam logic [1:0] VBITS_MPEG1  = 2'd3;
	localparam logic [1:0] VBITS_MPEG2  = 2'd2;
	localparam logic [1:0] VBITS_MPEG25 = 2'd0;
	localparam logic [1:0] VER_MPEG1    = 2'd0;
	localparam logic [1:0] VER_MPEG2    = 2'd1;
	localparam logic [1:0] VER_MPEG25   = 2'd2;

	localparam logic [1:0] LBITS_RESERVED = 2'd0;
	localparam logic [3:0] BIDX_FREE      = 4'd0;
	localparam logic [3:0] BIDX_BAD       = 4'd15;
	localparam logic [1:0] SIDX_RESERVED  = 2'd3;

	localparam int KBPS_W   = 9;
	localparam int BR_W     = 19;
	localparam int SR_W     = 16;
	localparam int FB_W     = 12;
	localparam int RECIP_SH = 32;
	localparam int RECIP_W  = 37;
	localparam int PROD_W   = KBPS_W + RECIP_W;

	typedef logic [KBPS_W-1:0]  kbps_t;
	typedef logic [SR_W-1:0]    sr_t;
	typedef logic [RECIP_W-1:0] recip_t;

	localparam logic [9:0] KBPS_SCALE = 10'd1000;

	// [group][layer-1][index], group 0 mpeg-1, group 1 mpeg-2 and 2.5
	localparam kbps_t BR_KBPS [0:1][0:2][0:15] = '{
		'{
			'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
			  9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
			  9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
			'{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
			  9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
		},
		'{
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
			  9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
			  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
			  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
		}
	};

	// [version][rate index], reserved index handled outside
	localparam sr_t SR_HZ [0:2][0:2] = '{
		'{16'd44100, 16'd48000, 16'd32000},
		'{16'd22050, 16'd24000, 16'd16000},
		'{16'd11025, 16'd12000, 16'd8000}
	};

	// ceil(2^32 * bytes_per_kbps / rate); exact quotient for kbps up to 448
	localparam logic [63:0] SCALE_L1  = 64'd12000 << RECIP_SH;
	localparam logic [63:0] SCALE_L23 = 64'd144000 << RECIP_SH;

	localparam recip_t RECIP_L1 [0:2][0:2] = '{
		'{RECIP_W'((SCALE_L1 + 64'd44099) / 64'd44100),
		  RECIP_W'((SCALE_L1 + 64'd47999) / 64'd48000),
		  RECIP_W'((SCALE_L1 + 64'd31999) / 64'd32000)},
		'{RECIP_W'((SCALE_L1 + 64'd22049) / 64'd22050),
		  RECIP_W'((SCALE_L1 + 64'd23999) / 64'd24000),
		  RECIP_W'((SCALE_L1 + 64'd15999) / 64'd16000)},
		'{RECIP_W'((SCALE_L1 + 64'd11024) / 64'd11025),
		  RECIP_W'((SCALE_L1 + 64'd11999) / 64'd12000),
		  RECIP_W'((SCALE_L1 + 64'd7999) / 64'd8000)}
	};

	localparam recip_t RECIP_L23 [0:2][0:2] = '{
		'{RECIP_W'((SCALE_L23 + 64'd44099) / 64'd44100),
		  RECIP_W'((SCALE_L23 + 64'd47999) / 64'd48000),
		  RECIP_W'((SCALE_L23 + 64'd31999) / 64'd32000)},
		'{RECIP_W'((SCALE_L23 + 64'd22049) / 64'd22050),
		  RECIP_W'((SCALE_L23 + 64'd23999) / 64'd24000),
		  RECIP_W'((SCALE_L23 + 64'd15999) / 64'd16000)},
		'{RECIP_W'((SCALE_L23 + 64'd11024) / 64'd11025),
		  RECIP_W'((SCALE_L23 + 64'd11999) / 64'd12000),
		  RECIP_W'((SCALE_L23 + 64'd7999) / 64'd8000)}
	};

endpackage

FILE: rtl/core/mpeg_audio_header_decode.sv
// an accepted request passes the stage 1, stage 2 and stage 3 registers to its result on the master side
// throughput: one header word per cycle; the pipeline moves as a whole and holds on
// backpressure, stage 1 does checks and table lookups, stage 2 the reciprocal multiply,
// stage 3 padding, layer scaling and zeroing of rejected words
// reset: arst_n asynchronous active low clears the stage valid bits only
// depends on mahd_pkg
module mpeg_audio_header_decode (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // header_word[31:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// version_code[1:0], layer_number[3:2], protection_bit[4], bitrate_bps[23:5],
	// sample_rate_hz[39:24], padding_bit[40], frame_bytes[52:41], zero[55:53]
	output logic [55:0] m_axis_tdata,
	output logic [2:0]  m_axis_tuser    // status[2:0]
);
	import mahd_pkg::*;

	logic en;

	// stage 1 decode
	logic [1:0] vbits, lbits, sidx, ver, lidx, sidx_safe;
	logic [3:0] bidx;
	logic       ver_ok;
	status_t    status_d;
	kbps_t      kbps_d;
	sr_t        sr_d;
	recip_t     recip_d;

	logic       valid_s1, valid_s2, valid_s3;
	status_t    status_s1, status_s2;
	logic [1:0] ver_s1, ver_s2, layer_s1, layer_s2;
	logic       prot_s1, prot_s2, pad_s1, pad_s2;
	kbps_t      kbps_s1;
	sr_t        sr_s1, sr_s2;
	recip_t     recip_s1;
	logic [BR_W-1:0] br_s2;
	logic [FB_W-1:0] quot_s2;
	logic [PROD_W-1:0] prod;
	logic [FB_W-1:0] fb_d;

	logic [2:0]       status_s3;
	logic [1:0]       ver_s3, layer_s3;
	logic             prot_s3, pad_s3;
	logic [BR_W-1:0]  br_s3;
	logic [SR_W-1:0]  sr_s3;
	logic [FB_W-1:0]  fb_s3;

	assign en            = !valid_s3 || m_axis_tready;
	assign s_axis_tready = en;

	assign vbits = s_axis_tdata[20:19];
	assign lbits = s_axis_tdata[18:17];
	assign bidx  = s_axis_tdata[15:12];
	assign sidx  = s_axis_tdata[11:10];

	always_comb begin
		ver_ok = 1'b1;
		case (vbits)
			VBITS_MPEG1:  ver = VER_MPEG1;
			VBITS_MPEG2:  ver = VER_MPEG2;
			VBITS_MPEG25: ver = VER_MPEG25;
			default: begin
				ver    = VER_MPEG1;
				ver_ok = 1'b0;
			end
		endcase
		// layer I at index 0, layer III at index 2
		lidx      = (lbits == LBITS_RESERVED) ? 2'd0 : 2'd3 - lbits;
		sidx_safe = (sidx == SIDX_RESERVED) ? 2'd0 : sidx;
		kbps_d    = BR_KBPS[(ver == VER_MPEG1) ? 1'b0 : 1'b1][lidx][bidx];
		sr_d      = SR_HZ[ver][sidx_safe];
		recip_d   = (lidx == 2'd0) ? RECIP_L1[ver][sidx_safe] : RECIP_L23[ver][sidx_safe];

		if ((s_axis_tdata & SYNC_MASK) != SYNC_MASK)
			status_d = ST_NO_SYNC;
		else if (!ver_ok)
			status_d = ST_BAD_VERSION;
		else if (lbits == LBITS_RESERVED)
			status_d = ST_BAD_LAYER;
		else if (bidx == BIDX_FREE || bidx == BIDX_BAD || sidx == SIDX_RESERVED)
			status_d = ST_BAD_RATE;
		else
			status_d = ST_OK;
	end

	assign prod = PROD_W'(kbps_s1) * PROD_W'(recip_s1);

	always_comb begin
		if (layer_s2 == 2'd1)
			fb_d = FB_W'((quot_s2 + FB_W'(pad_s2)) << 2);
		else
			fb_d = quot_s2 + FB_W'(pad_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_s1 <= status_d;
			ver_s1    <= ver;
			layer_s1  <= lidx + 2'd1;
			prot_s1   <= s_axis_tdata[16];
			pad_s1    <= s_axis_tdata[9];
			kbps_s1   <= kbps_d;
			sr_s1     <= sr_d;
			recip_s1  <= recip_d;

			status_s2 <= status_s1;
			ver_s2    <= ver_s1;
			layer_s2  <= layer_s1;
			prot_s2   <= prot_s1;
			pad_s2    <= pad_s1;
			sr_s2     <= sr_s1;
			br_s2     <= BR_W'(kbps_s1) * BR_W'(KBPS_SCALE);
			quot_s2   <= prod[RECIP_SH +: FB_W];

			// rejected words carry only their status
			status_s3 <= status_s2;
			if (status_s2 == ST_OK) begin
				ver_s3   <= ver_s2;
				layer_s3 <= layer_s2;
				prot_s3  <= prot_s2;
				pad_s3   <= pad_s2;
				br_s3    <= br_s2;
				sr_s3    <= sr_s2;
				fb_s3    <= fb_d;
			end else begin
				ver_s3   <= '0;
				layer_s3 <= '0;
				prot_s3  <= 1'b0;
				pad_s3   <= 1'b0;
				br_s3    <= '0;
				sr_s3    <= '0;
				fb_s3    <= '0;
			end
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tuser  = status_s3;
	assign m_axis_tdata  = {3'b000, fb_s3, pad_s3, sr_s3, br_s3, prot_s3, layer_s3, ver_s3};

endmodule

FILE: dv/mpeg_audio_header_decode_test.sv
// self-checking bench for mpeg_audio_header_decode: a directed table, then random header words
// under several idle and stall mixes, each result compared with a local decode of the word
// depends on mahd_pkg and the mpeg_audio_header_decode rtl
module mpeg_audio_header_decode_test;
	import mahd_pkg::*;

	typedef struct packed {
		status_t     status;
		logic [1:0]  version_code;
		logic [1:0]  layer_number;
		logic        protection_bit;
		logic [18:0] bitrate_bps;
		logic [15:0] sample_rate_hz;
		logic        padding_bit;
		logic [11:0] frame_bytes;
	} hdr_decode_t;

	typedef struct packed {
		logic [31:0] word;
		logic        typed;
		hdr_decode_t decode;
	} hdr_row_t;

	localparam int ROW_COUNT       = 22;
	localparam int WORDS_PER_PHASE = 335;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int PHASE_COUNT     = 4;

	localparam int IDLE_PCT  [PHASE_COUNT] = '{0, 55, 0, 11};
	localparam int STALL_PCT [PHASE_COUNT] = '{0, 0, 55, 11};

	localparam hdr_decode_t NO_DECODE = '0;

	// [group][layer-1][index]: group 0 mpeg-1, group 1 mpeg-2 and 2.5
	localparam int unsigned KBPS_BY_LAYER [2][3][16] = '{
		'{
			'{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
			'{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
			'{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}
		},
		'{
			'{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
			'{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
			'{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
		}
	};

	localparam int unsigned HZ_BY_VERSION [3][4] = '{
		'{44100, 48000, 32000, 0},
		'{22050, 24000, 16000, 0},
		'{11025, 12000, 8000, 0}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	int idle_pct  = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int cycle_count = 0;

	hdr_decode_t offered_decodes [$];
	hdr_decode_t awaited_decodes [$];

	hdr_row_t directed_rows [ROW_COUNT] = '{
		'{32'h0000_0000, 1'b1, '{ST_NO_SYNC, 2'd0, 2'd0, 1'b0, 19'd0, 16'd0, 1'b0, 12'd0}},
		'{32'h7FFF_FFFF, 1'b1, '{ST_NO_SYNC, 2'd0, 2'd0, 1'b0, 19'd0, 16'd0, 1'b0, 12'd0}},
		'{32'hFFDF_FFFF, 1'b1, '{ST_NO_SYNC, 2'd0, 2'd0, 1'b0, 19'd0, 16'd0, 1'b0, 12'd0}},
		'{32'hFFEF_FFFF, 1'b1, '{ST_BAD_VERSION, 2'd0, 2'd0, 1'b0, 19'd0, 16'd0, 1'b0, 12'd0}},
		// reserved version wins over reserved layer
		'{32'hFFE9_FFFF, 1'b1, '{ST_BAD_VERSION, 2'd0, 2'd0, 1'b0, 19'd0, 16'd0, 1'b0, 12'd0}},
		'{32'hFFF9_FFFF, 1'b1, '{ST_BAD_LAYER, 2'd0, 2'd0, 1'b0, 19'd0, 16'd0, 1'b0, 12'd0}},
		'{32'hFFE1_0000, 1'b1, '{ST_BAD_LAYER, 2'd0, 2'd0, 1'b0, 19'd0, 16'd0, 1'b0, 12'd0}},
		// free format, forbidden index, reserved rate
		'{32'hFFFB_0000, 1'b1, '{ST_BAD_RATE, 2'd0, 2'd0, 1'b0, 19'd0, 16'd0, 1'b0, 12'd0}},
		'{32'hFFFB_F000, 1'b1, '{ST_BAD_RATE, 2'd0, 2'd0, 1'b0, 19'd0, 16'd0, 1'b0, 12'd0}},
		'{32'hFFFB_9C00, 1'b1, '{ST_BAD_RATE, 2'd0, 2'd0, 1'b0, 19'd0, 16'd0, 1'b0, 12'd0}},
		'{32'hFFFF_FFFF, 1'b1, '{ST_BAD_RATE, 2'd0, 2'd0, 1'b0, 19'd0, 16'd0, 1'b0, 12'd0}},
		'{32'hFFFB_9064, 1'b1, '{ST_OK, VER_MPEG1, 2'd3, 1'b1, 19'd128000, 16'd44100, 1'b0,
			12'd417}},
		// longest frame: mpeg-2.5 layer iii with the 144 factor
		'{32'hFFE3_EAFF, 1'b1, '{ST_OK, VER_MPEG25, 2'd3, 1'b1, 19'd160000, 16'd8000, 1'b1,
			12'd2881}},
		'{32'hFFF2_1400, 1'b1, '{ST_OK, VER_MPEG2, 2'd3, 1'b0, 19'd8000, 16'd24000, 1'b0,
			12'd48}},
		'{32'hFFFF_E2FF, 1'b0, NO_DECODE},
		'{32'hFFFD_E800, 1'b0, NO_DECODE},
		'{32'hFFF3_D600, 1'b0, NO_DECODE},
		'{32'hFFF6_E000, 1'b0, NO_DECODE},
		'{32'hFFF4_5A00, 1'b0, NO_DECODE},
		'{32'hFFE6_1800, 1'b0, NO_DECODE},
		'{32'hFFE4_7600, 1'b0, NO_DECODE},
		'{32'hFFFB_1400, 1'b0, NO_DECODE}
	};

	mpeg_audio_header_decode DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic hdr_decode_t decode_header(input logic [31:0] w);
		hdr_decode_t d;
		logic [1:0]  ver;
		int unsigned grp, lay, kbps, hz, bps, len;
		d = '0;
		if ((w & SYNC_MASK) != SYNC_MASK) begin
			d.status = ST_NO_SYNC;
			return d;
		end
		case (w[20:19])
			VBITS_MPEG1:  ver = VER_MPEG1;
			VBITS_MPEG2:  ver = VER_MPEG2;
			VBITS_MPEG25: ver = VER_MPEG25;
			default: begin
				d.status = ST_BAD_VERSION;
				return d;
			end
		endcase
		if (w[18:17] == LBITS_RESERVED) begin
			d.status = ST_BAD_LAYER;
			return d;
		end
		lay = 4 - w[18:17];
		grp = (ver == VER_MPEG1) ? 0 : 1;
		kbps = KBPS_BY_LAYER[grp][lay-1][w[15:12]];
		hz = HZ_BY_VERSION[ver][w[11:10]];
		if (kbps == 0 || hz == 0) begin
			d.status = ST_BAD_RATE;
			return d;
		end
		bps = kbps * 1000;
		if (lay == 1)
			len = (12 * bps / hz + w[9]) * 4;
		else
			len = 144 * bps / hz + w[9];
		d.status         = ST_OK;
		d.version_code   = ver;
		d.layer_number   = 2'(lay);
		d.protection_bit = w[16];
		d.bitrate_bps    = 19'(bps);
		d.sample_rate_hz = 16'(hz);
		d.padding_bit    = w[9];
		d.frame_bytes    = 12'(len);
		return d;
	endfunction

	// mostly synced words with plausible fields, some near-miss syncs, some raw noise
	function automatic logic [31:0] random_header();
		logic [31:0] w;
		int          pick;
		pick = $urandom_range(99);
		w = $urandom();
		if (pick < 80) begin
			w[31:21] = '1;
			if ($urandom_range(19) != 0) begin
				case ($urandom_range(2))
					0:       w[20:19] = VBITS_MPEG1;
					1:       w[20:19] = VBITS_MPEG2;
					default: w[20:19] = VBITS_MPEG25;
				endcase
			end
			if ($urandom_range(19) != 0 && w[18:17] == LBITS_RESERVED)
				w[18:17] = 2'($urandom_range(1, 3));
			if ($urandom_range(9) != 0)
				w[15:12] = 4'($urandom_range(1, 14));
			if ($urandom_range(9) != 0 && w[11:10] == SIDX_RESERVED)
				w[11:10] = 2'($urandom_range(0, 2));
		end else if (pick < 88) begin
			w[31:21] = '1;
			w[31:21] = w[31:21] ^ (11'd1 << $urandom_range(10));
		end
		return w;
	endfunction

	task automatic offer_header(input logic [31:0] w, input hdr_decode_t want);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		offered_decodes.push_back(want);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_decodes();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (awaited_decodes.size() != 0 || offered_decodes.size() != 0);
	endtask

	task automatic check_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk)
		m_axis_tready <= arst_n && ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		hdr_decode_t want;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("%0t: timeout with %0d results pending", $time, awaited_decodes.size());
				$display("CHECKS FAILED");
				$finish;
			end else begin
				if (s_axis_tvalid && s_axis_tready)
					awaited_decodes.push_back(offered_decodes.pop_front());
				if (m_axis_tvalid && m_axis_tready) begin
					if (awaited_decodes.size() == 0) begin
						$display("%0t: result expected none got status %0d data %h", $time,
							m_axis_tuser, m_axis_tdata);
						mismatches++;
					end else begin
						want = awaited_decodes.pop_front();
						check_field("status", want.status, m_axis_tuser);
						check_field("version_code", want.version_code, m_axis_tdata[1:0]);
						check_field("layer_number", want.layer_number, m_axis_tdata[3:2]);
						check_field("protection_bit", want.protection_bit, m_axis_tdata[4]);
						check_field("bitrate_bps", want.bitrate_bps, m_axis_tdata[23:5]);
						check_field("sample_rate_hz", want.sample_rate_hz, m_axis_tdata[39:24]);
						check_field("padding_bit", want.padding_bit, m_axis_tdata[40]);
						check_field("frame_bytes", want.frame_bytes, m_axis_tdata[52:41]);
						check_field("unused tdata bits", 0, m_axis_tdata[55:53]);
					end
				end
			end
		end
	end

	initial begin
		logic [31:0] w;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			offer_header(directed_rows[i].word, directed_rows[i].typed ?
				directed_rows[i].decode : decode_header(directed_rows[i].word));
		end
		// sender holds off until the pipeline is empty
		drain_decodes();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			idle_pct  = IDLE_PCT[p];
			stall_pct = STALL_PCT[p];
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				w = random_header();
				offer_header(w, decode_header(w));
			end
			drain_decodes();
		end

		// catch any stray result after the last expected one
		repeat (10) @(posedge clk);
		if (mismatches == 0 && awaited_decodes.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
